/* rtl/hts_pkg.sv */
// Shared types and constants for the HID to PS/2 scan code queue.
package hts_pkg;

  // Default sizes for the top-level parameters.
  localparam int RING_DEPTH_DEF = 128;
  localparam int MAX_READ_DEF   = 64;

  // Depths of the command queue and the result queue.
  localparam int CQ_DEPTH = 2;
  localparam int RQ_DEPTH = 4;

  // Field widths fixed by the interface.
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 7;
  localparam int FILL_W = 7;

  // Scan code constants.
  localparam logic [BYTE_W-1:0] PREFIX_BYTE = 8'hE0;
  localparam logic [BYTE_W-1:0] BREAK_BIT   = 8'h80;
  localparam logic [BYTE_W-1:0] MOD_FIRST   = 8'hE0;
  localparam logic [BYTE_W-1:0] MOD_LAST    = 8'hE7;
  localparam logic [FILL_W-1:0] FILL_MAX    = 7'd127;

  // Input command codes.
  typedef enum logic {
    IN_KEY  = 1'b0,
    IN_READ = 1'b1
  } in_cmd_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_KEY_MAPPED   = 2'd0,
    ST_KEY_UNMAPPED = 2'd1,
    ST_READ_BYTE    = 2'd2,
    ST_READ_NONE    = 2'd3
  } status_t;

  // Classified work handed from the front to the back.
  typedef enum logic [1:0] {
    CMD_KEY_MAP   = 2'd0,
    CMD_KEY_UNMAP = 2'd1,
    CMD_READ      = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic              prefix;
    logic [BYTE_W-1:0] code;
    logic [CNT_W-1:0]  count;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] scan_byte;
    logic [FILL_W-1:0] fill_level;
    logic              last;
  } res_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_CODE = 2'd1,
    BK_READ = 2'd2
  } bk_state_t;

endpackage

/* rtl/hts_ram.sv */
// Generic single-port RAM with registered read data.
module hts_ram
  #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
  ) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/hts_fifo.sv */
// Small register-based queue used for commands and for results.
module hts_fifo
  #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
  ) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_r [DEPTH];
  logic [IW-1:0]    wp_r, wp_nxt;
  logic [IW-1:0]    rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign dout    = data_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointer and count update.
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == IW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == IW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wp_r] <= din;
    end
  end

endmodule

/* rtl/hts_front.sv */
// Front end: accepts input beats and classifies key events by table lookup.
module hts_front
  import hts_pkg::*;
  #(
  parameter int MAX_READ = MAX_READ_DEF
  ) (
  input  logic              in_push,
  input  logic              in_cmd,
  input  logic [BYTE_W-1:0] in_usage_id,
  input  logic              in_pressed,
  input  logic [CNT_W-1:0]  in_max_bytes,
  input  logic              cq_full,
  output logic              cq_push,
  output cmd_t              cq_cmd
);

  // Modifier keys E0-E7: make code.
  function automatic logic [BYTE_W-1:0] mod_code(input logic [2:0] m);
    logic [BYTE_W-1:0] c;
    unique case (m)
      3'd0:    c = 8'h1D;
      3'd1:    c = 8'h2A;
      3'd2:    c = 8'h38;
      3'd3:    c = 8'h5B;
      3'd4:    c = 8'h1D;
      3'd5:    c = 8'h36;
      3'd6:    c = 8'h38;
      default: c = 8'h5C;
    endcase
    return c;
  endfunction

  // Left GUI, Right Ctrl, Right Alt and Right GUI carry the prefix.
  function automatic logic mod_prefix(input logic [2:0] m);
    return (m == 3'd3) || (m == 3'd4) || (m == 3'd6) || (m == 3'd7);
  endfunction

  // Extended keys; a zero result means the usage is not in the list.
  function automatic logic [BYTE_W-1:0] ext_code(input logic [BYTE_W-1:0] u);
    logic [BYTE_W-1:0] c;
    case (u)
      8'h49:   c = 8'h52;
      8'h4A:   c = 8'h47;
      8'h4B:   c = 8'h49;
      8'h4C:   c = 8'h53;
      8'h4D:   c = 8'h4F;
      8'h4E:   c = 8'h51;
      8'h4F:   c = 8'h4D;
      8'h50:   c = 8'h4B;
      8'h51:   c = 8'h50;
      8'h52:   c = 8'h48;
      8'h54:   c = 8'h35;
      8'h58:   c = 8'h1C;
      8'h65:   c = 8'h5D;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Main table; zero means unmapped.
  function automatic logic [BYTE_W-1:0] main_code(input logic [BYTE_W-1:0] u);
    logic [BYTE_W-1:0] c;
    case (u)
      8'h04: c = 8'h1E;  8'h05: c = 8'h30;  8'h06: c = 8'h2E;  8'h07: c = 8'h20;
      8'h08: c = 8'h12;  8'h09: c = 8'h21;  8'h0A: c = 8'h22;  8'h0B: c = 8'h23;
      8'h0C: c = 8'h17;  8'h0D: c = 8'h24;  8'h0E: c = 8'h25;  8'h0F: c = 8'h26;
      8'h10: c = 8'h32;  8'h11: c = 8'h31;  8'h12: c = 8'h18;  8'h13: c = 8'h19;
      8'h14: c = 8'h10;  8'h15: c = 8'h13;  8'h16: c = 8'h1F;  8'h17: c = 8'h14;
      8'h18: c = 8'h16;  8'h19: c = 8'h2F;  8'h1A: c = 8'h11;  8'h1B: c = 8'h2D;
      8'h1C: c = 8'h15;  8'h1D: c = 8'h2C;  8'h1E: c = 8'h02;  8'h1F: c = 8'h03;
      8'h20: c = 8'h04;  8'h21: c = 8'h05;  8'h22: c = 8'h06;  8'h23: c = 8'h07;
      8'h24: c = 8'h08;  8'h25: c = 8'h09;  8'h26: c = 8'h0A;  8'h27: c = 8'h0B;
      8'h28: c = 8'h1C;  8'h29: c = 8'h01;  8'h2A: c = 8'h0E;  8'h2B: c = 8'h0F;
      8'h2C: c = 8'h39;  8'h2D: c = 8'h0C;  8'h2E: c = 8'h0D;  8'h2F: c = 8'h1A;
      8'h30: c = 8'h1B;  8'h31: c = 8'h2B;  8'h32: c = 8'h2B;  8'h33: c = 8'h27;
      8'h34: c = 8'h28;  8'h35: c = 8'h29;  8'h36: c = 8'h33;  8'h37: c = 8'h34;
      8'h38: c = 8'h35;  8'h39: c = 8'h3A;  8'h3A: c = 8'h3B;  8'h3B: c = 8'h3C;
      8'h3C: c = 8'h3D;  8'h3D: c = 8'h3E;  8'h3E: c = 8'h3F;  8'h3F: c = 8'h40;
      8'h40: c = 8'h41;  8'h41: c = 8'h42;  8'h42: c = 8'h43;  8'h43: c = 8'h44;
      8'h44: c = 8'h57;  8'h45: c = 8'h58;  8'h47: c = 8'h46;  8'h53: c = 8'h45;
      8'h55: c = 8'h37;  8'h56: c = 8'h4A;  8'h57: c = 8'h4E;  8'h59: c = 8'h4F;
      8'h5A: c = 8'h50;  8'h5B: c = 8'h51;  8'h5C: c = 8'h4B;  8'h5D: c = 8'h4C;
      8'h5E: c = 8'h4D;  8'h5F: c = 8'h47;  8'h60: c = 8'h48;  8'h61: c = 8'h49;
      8'h62: c = 8'h52;  8'h63: c = 8'h53;  8'h64: c = 8'h56;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  logic              is_mod;
  logic [BYTE_W-1:0] ext_c, main_c;
  logic              found, prefix;
  logic [BYTE_W-1:0] make_c;

  assign cq_push = in_push && !cq_full;
  assign is_mod  = (in_usage_id >= MOD_FIRST) && (in_usage_id <= MOD_LAST);
  assign ext_c   = ext_code(in_usage_id);
  assign main_c  = main_code(in_usage_id);

  // Lookup priority: modifiers, then extended keys, then the main table.
  always_comb begin
    found  = 1'b1;
    prefix = 1'b0;
    make_c = '0;
    priority if (is_mod) begin
      make_c = mod_code(in_usage_id[2:0]);
      prefix = mod_prefix(in_usage_id[2:0]);
    end else if (ext_c != '0) begin
      make_c = ext_c;
      prefix = 1'b1;
    end else if (main_c != '0) begin
      make_c = main_c;
    end else begin
      found = 1'b0;
    end
  end

  // Build the command for the back end.
  always_comb begin
    cq_cmd.prefix = prefix;
    cq_cmd.code   = in_pressed ? make_c : (make_c | BREAK_BIT);
    cq_cmd.count  = (in_max_bytes > CNT_W'(MAX_READ)) ? CNT_W'(MAX_READ) : in_max_bytes;
    if (in_cmd == IN_READ) begin
      cq_cmd.kind = CMD_READ;
    end else if (found) begin
      cq_cmd.kind = CMD_KEY_MAP;
    end else begin
      cq_cmd.kind = CMD_KEY_UNMAP;
    end
  end

endmodule

/* rtl/hts_back.sv */
// Back end: pushes scan codes into the byte ring and pops them for reads.
module hts_back
  import hts_pkg::*;
  #(
  parameter int RING_DEPTH = RING_DEPTH_DEF
  ) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cq_empty,
  input  cmd_t                          cq_cmd,
  output logic                          cq_pop,
  output logic                          rq_push,
  output res_t                          rq_res,
  input  logic [$clog2(RQ_DEPTH+1)-1:0] rq_count
);

  localparam int AW = $clog2(RING_DEPTH);

  bk_state_t         state_r, state_nxt;
  logic [AW-1:0]     wp_r, wp_nxt;
  logic [AW-1:0]     rp_r, rp_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic              pend_r, pend_nxt;
  logic [FILL_W-1:0] pend_fill_r, pend_fill_nxt;
  logic              pend_last_r, pend_last_nxt;

  logic              push_en, pop_en;
  logic [BYTE_W-1:0] push_data;
  logic              ring_full;
  logic [AW-1:0]     cnt_push;
  logic              room, issue_ok, read_none;
  logic [BYTE_W-1:0] ram_rdata;

  // Saturate the queued count to the result field.
  function automatic logic [FILL_W-1:0] sat_fill(input logic [AW-1:0] v);
    return (32'(v) > 32'(FILL_MAX)) ? FILL_MAX : FILL_W'(v);
  endfunction

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign ring_full = (cnt_r == AW'(RING_DEPTH - 1));
  assign cnt_push  = ring_full ? cnt_r : cnt_r + 1'b1;
  assign room      = !pend_r && (32'(rq_count) < 32'(RQ_DEPTH));
  assign issue_ok  = (32'(rq_count) + 32'(pend_r)) < 32'(RQ_DEPTH);
  assign read_none = (cnt_r == '0) || (cq_cmd.count == '0);

  // Sequencer: next state, ring requests and result beats.
  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    pend_nxt      = 1'b0;
    pend_fill_nxt = pend_fill_r;
    pend_last_nxt = pend_last_r;
    push_en       = 1'b0;
    push_data     = '0;
    pop_en        = 1'b0;
    cq_pop        = 1'b0;
    rq_push       = 1'b0;
    rq_res        = '0;
    if (pend_r) begin
      rq_push           = 1'b1;
      rq_res.status     = ST_READ_BYTE;
      rq_res.scan_byte  = ram_rdata;
      rq_res.fill_level = pend_fill_r;
      rq_res.last       = pend_last_r;
    end
    unique case (state_r)
      BK_IDLE: begin
        if (!cq_empty) begin
          unique case (cq_cmd.kind)
            CMD_KEY_UNMAP: begin
              if (room) begin
                rq_push           = 1'b1;
                rq_res.status     = ST_KEY_UNMAPPED;
                rq_res.fill_level = sat_fill(cnt_r);
                rq_res.last       = 1'b1;
                cq_pop            = 1'b1;
              end
            end
            CMD_KEY_MAP: begin
              if (cq_cmd.prefix) begin
                push_en   = 1'b1;
                push_data = PREFIX_BYTE;
              end
              state_nxt = BK_CODE;
            end
            CMD_READ: begin
              if (read_none) begin
                if (room) begin
                  rq_push           = 1'b1;
                  rq_res.status     = ST_READ_NONE;
                  rq_res.fill_level = sat_fill(cnt_r);
                  rq_res.last       = 1'b1;
                  cq_pop            = 1'b1;
                end
              end else begin
                rem_nxt   = (32'(cnt_r) < 32'(cq_cmd.count)) ? CNT_W'(cnt_r) : cq_cmd.count;
                state_nxt = BK_READ;
              end
            end
            default: begin
              state_nxt = BK_IDLE;
            end
          endcase
        end
      end
      BK_CODE: begin
        if (room) begin
          push_en           = 1'b1;
          push_data         = cq_cmd.code;
          rq_push           = 1'b1;
          rq_res.status     = ST_KEY_MAPPED;
          rq_res.fill_level = sat_fill(cnt_push);
          rq_res.last       = 1'b1;
          cq_pop            = 1'b1;
          state_nxt         = BK_IDLE;
        end
      end
      BK_READ: begin
        if (issue_ok) begin
          pop_en        = 1'b1;
          pend_nxt      = 1'b1;
          pend_fill_nxt = sat_fill(cnt_r - 1'b1);
          pend_last_nxt = (rem_r == CNT_W'(1));
          rem_nxt       = rem_r - 1'b1;
          if (rem_r == CNT_W'(1)) begin
            cq_pop    = 1'b1;
            state_nxt = BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Ring pointers; a push into a full ring drops the oldest byte.
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push_en) begin
      wp_nxt  = ptr_inc(wp_r);
      cnt_nxt = cnt_push;
      if (ring_full) begin
        rp_nxt = ptr_inc(rp_r);
      end
    end else if (pop_en) begin
      rp_nxt  = ptr_inc(rp_r);
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      wp_r    <= '0;
      rp_r    <= '0;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    pend_fill_r <= pend_fill_nxt;
    pend_last_r <= pend_last_nxt;
  end

  // Byte ring storage.
  hts_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .en    (push_en || pop_en),
    .we    (push_en),
    .addr  (pop_en ? rp_r : wp_r),
    .wdata (push_data),
    .rdata (ram_rdata)
  );

  // The ring port serves one access per cycle.
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_en && pop_en))
    else $error("ring push and pop in the same cycle");

  // The fill count always matches the pointer distance.
  a_cnt_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) == ((32'(wp_r) >= 32'(rp_r)) ? 32'(wp_r) - 32'(rp_r)
                   : 32'(wp_r) + 32'(RING_DEPTH) - 32'(rp_r)))
    else $error("fill count out of step with ring pointers");

  // A read never pops an empty ring.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop_en |-> (cnt_r != '0))
    else $error("pop from empty ring");

  // Result beats only go to a queue with space.
  a_rq_room: assert property (@(posedge clk) disable iff (!rst_n)
    rq_push |-> (32'(rq_count) < 32'(RQ_DEPTH)))
    else $error("result beat into full queue");

  // A popped byte is always delivered in the following cycle.
  a_pend_follow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_en |=> (pend_r && rq_push))
    else $error("popped byte not delivered");

endmodule

/* rtl/hid_to_ps2_scancode_fifo.sv */
// Top level of the HID usage to PS/2 Set 1 scan code queue.
//
//   Channel   Ports                                         Handshake
//   input     in_cmd in_usage_id in_pressed in_max_bytes    in_push / in_full
//   result    out_status out_scan_byte out_fill_level       out_pop / out_empty
//             out_last
//
// An accepted beat waits in a two-entry command queue; the back end then answers
// an unmapped key or an empty read directly from idle, a mapped key through the
// code state after any prefix byte, and a read by popping one byte at a time,
// paced by the single port of the ring RAM and a four-entry result queue.
// Reset is synchronous; the ring contents are not cleared, the pointers and
// fill count are, so no clearing pass is needed.
// A stalled result side fills the result queue and then holds the back end,
// while the command queue keeps taking input beats until it is full.
module hid_to_ps2_scancode_fifo
  import hts_pkg::*;
  #(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int MAX_READ   = MAX_READ_DEF
  ) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic              in_cmd,
  input  logic [BYTE_W-1:0] in_usage_id,
  input  logic              in_pressed,
  input  logic [CNT_W-1:0]  in_max_bytes,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [1:0]        out_status,
  output logic [BYTE_W-1:0] out_scan_byte,
  output logic [FILL_W-1:0] out_fill_level,
  output logic              out_last
);

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

  logic                          cq_push, cq_full, cq_empty, cq_pop;
  cmd_t                          cq_cmd_in;
  logic [CMD_W-1:0]              cq_dout;
  logic [$clog2(CQ_DEPTH+1)-1:0] cq_count;
  logic                          rq_push, rq_full;
  res_t                          rq_res, rq_head;
  logic [RES_W-1:0]              rq_dout;
  logic [$clog2(RQ_DEPTH+1)-1:0] rq_count;

  // Accept and classify input beats.
  hts_front #(
    .MAX_READ (MAX_READ)
  ) u_front (
    .in_push      (in_push),
    .in_cmd       (in_cmd),
    .in_usage_id  (in_usage_id),
    .in_pressed   (in_pressed),
    .in_max_bytes (in_max_bytes),
    .cq_full      (cq_full),
    .cq_push      (cq_push),
    .cq_cmd       (cq_cmd_in)
  );

  // Command queue between front and back.
  hts_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CQ_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cq_push),
    .din   (CMD_W'(cq_cmd_in)),
    .full  (cq_full),
    .pop   (cq_pop),
    .dout  (cq_dout),
    .empty (cq_empty),
    .count (cq_count)
  );

  assign in_full = cq_full || (32'(cq_count) >= 32'(CQ_DEPTH));

  // Ring and sequencer.
  hts_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cq_empty (cq_empty),
    .cq_cmd   (cmd_t'(cq_dout)),
    .cq_pop   (cq_pop),
    .rq_push  (rq_push),
    .rq_res   (rq_res),
    .rq_count (rq_count)
  );

  // Result queue toward the output ports.
  hts_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RQ_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rq_push),
    .din   (RES_W'(rq_res)),
    .full  (rq_full),
    .pop   (out_pop),
    .dout  (rq_dout),
    .empty (out_empty),
    .count (rq_count)
  );

  assign rq_head        = res_t'(rq_dout);
  assign out_status     = rq_head.status;
  assign out_scan_byte  = rq_head.scan_byte;
  assign out_fill_level = rq_head.fill_level;
  assign out_last       = rq_head.last;

  // The back end never pushes into a full result queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    rq_push |-> !rq_full)
    else $error("result queue overflow");

  // A command is only taken from a non-empty queue.
  a_cmd_pop: assert property (@(posedge clk) disable iff (!rst_n)
    cq_pop |-> !cq_empty)
    else $error("command popped from empty queue");

  // Every command pop comes with a result beat, or the last read byte follows in the next cycle.
  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cq_pop && !rq_push) |=> rq_push)
    else $error("command retired without a result");

endmodule
